// ===== hdl/wdj_pkg.sv =====
// shared constants, types and helper functions for the water descriptor jacobian
package wdj_pkg;

	localparam int CW         = 32;              // coordinate and result width
	localparam int VW         = CW + 1;          // bond vector component
	localparam int SQW        = 2 * CW;          // one squared component
	localparam int SW         = SQW + 2;         // sum of three squares
	localparam int FRAC       = 32;              // fraction bits added under the root
	localparam int LW         = (SW + FRAC) / 2; // bond length width
	localparam int ROOT_STEPS = LW;
	localparam int RW         = LW + 2;          // root remainder
	localparam int DW         = LW + 1;          // divider remainder and divisor
	localparam int QW         = 34;              // quotient bits
	localparam int NW         = DW + QW;         // full dividend
	localparam int NLANE      = 6;
	localparam int EW         = 32;              // unit vector component, q2.30
	localparam int Q30        = 30;
	localparam int UNIT_SHIFT = 49;              // quotient keeps two extra low bits
	localparam int COS_SHIFT  = 18;
	localparam int TW         = 34;              // cosine row numerator
	localparam int XW         = 40;              // row value before saturation
	localparam int NVAL       = 9;
	localparam int ROWS       = 3;
	localparam int CPI        = 3;

	localparam int ROW_MEAN = 0;
	localparam int ROW_DIFF = 1;
	localparam int ROW_COS  = 2;

	typedef logic [2:0][VW-1:0] vec3_t;

	typedef struct packed {
		vec3_t v1;
		vec3_t v2;
		logic  fin;
	} bond_t;

	typedef struct packed {
		logic [2:0][EW-1:0] e1;
		logic [2:0][EW-1:0] e2;
		logic [LW-1:0]      len1;
		logic [LW-1:0]      len2;
		logic [NLANE-1:0]   neg;
		logic               gt;
		logic               lt;
		logic               deg;
		logic               fin;
	} side_t;

	typedef logic [NVAL-1:0][CW-1:0] row_t;

	function automatic logic [CW-1:0] mag33(logic [VW-1:0] v);
		logic [VW-1:0] n;
		n = v[VW-1] ? -v : v;
		return n[CW-1:0];
	endfunction

	// rounded arithmetic shift, halves toward plus infinity
	function automatic logic signed [XW-1:0] rsh(logic signed [XW-1:0] x, int s);
		logic signed [XW-1:0] half;
		half = '0;
		half[s-1] = 1'b1;
		return (x + half) >>> s;
	endfunction

	function automatic logic [CW-1:0] sat(logic signed [XW-1:0] x);
		logic [XW-CW:0] top;
		top = x[XW-1:CW-1];
		if (top == '0 || top == '1)
			return x[CW-1:0];
		else if (x[XW-1])
			return {1'b1, {(CW-1){1'b0}}};
		else
			return {1'b0, {(CW-1){1'b1}}};
	endfunction

endpackage

// ===== hdl/wdj_root.sv =====
// pipelined digit by digit square root of both bond lengths
module wdj_root import wdj_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sum_valid,
	input  logic [1:0][SW-1:0]  sum,
	input  bond_t               bond,
	output logic                len_valid,
	output logic [1:0][LW-1:0]  len,
	output bond_t               bond_out
);

	logic [ROOT_STEPS:0] vld_s;
	logic [RW-1:0]       rem_s  [2][ROOT_STEPS+1];
	logic [LW-1:0]       root_s [2][ROOT_STEPS+1];
	logic [SW-1:0]       sum_s  [2][ROOT_STEPS+1];
	bond_t               bond_s [ROOT_STEPS+1];
	logic [1:0]          pair   [2][ROOT_STEPS];
	logic [RW+1:0]       tmp    [2][ROOT_STEPS];
	logic [RW+1:0]       trial  [2][ROOT_STEPS];
	logic                fit    [2][ROOT_STEPS];

	always_comb begin
		int idx;
		for (int k = 0; k < ROOT_STEPS; k++) begin
			for (int l = 0; l < 2; l++) begin
				// the low fraction pairs of the radicand are all zero
				idx = (2 * (ROOT_STEPS - 1 - k) >= FRAC) ? 2 * (ROOT_STEPS - 1 - k) - FRAC : 0;
				if (2 * (ROOT_STEPS - 1 - k) >= FRAC)
					pair[l][k] = sum_s[l][k][idx +: 2];
				else
					pair[l][k] = 2'b00;
				tmp[l][k]   = {rem_s[l][k], pair[l][k]};
				trial[l][k] = {2'b00, root_s[l][k], 2'b01};
				fit[l][k]   = tmp[l][k] >= trial[l][k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[ROOT_STEPS-1:0], sum_valid};
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			rem_s[l][0]  <= '0;
			root_s[l][0] <= '0;
			sum_s[l][0]  <= sum[l];
		end
		bond_s[0] <= bond;
		for (int k = 0; k < ROOT_STEPS; k++) begin
			for (int l = 0; l < 2; l++) begin
				rem_s[l][k+1]  <= fit[l][k] ? RW'(tmp[l][k] - trial[l][k]) : tmp[l][k][RW-1:0];
				root_s[l][k+1] <= {root_s[l][k][LW-2:0], fit[l][k]};
				sum_s[l][k+1]  <= sum_s[l][k];
			end
			bond_s[k+1] <= bond_s[k];
		end
	end

	assign len_valid = vld_s[ROOT_STEPS];
	assign len[0]    = root_s[0][ROOT_STEPS];
	assign len[1]    = root_s[1][ROOT_STEPS];
	assign bond_out  = bond_s[ROOT_STEPS];

endmodule

// ===== hdl/wdj_div.sv =====
// six lane pipelined restoring divider, one quotient bit per stage
module wdj_div import wdj_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   num_valid,
	input  logic [NLANE-1:0][DW-1:0] num_hi,
	input  logic [NLANE-1:0][QW-1:0] num_lo,
	input  logic [NLANE-1:0][DW-1:0] divisor,
	input  side_t                  side,
	output logic                   quo_valid,
	output logic [NLANE-1:0][QW-1:0] quo,
	output side_t                  side_out
);

	logic [QW:0]   vld_s;
	logic [DW-1:0] rem_s [NLANE][QW+1];
	logic [QW-1:0] lo_s  [NLANE][QW+1];
	logic [QW-1:0] q_s   [NLANE][QW+1];
	logic [DW-1:0] d_s   [NLANE][QW+1];
	side_t         side_s [QW+1];
	logic [DW:0]   tmp   [NLANE][QW];
	logic          fit   [NLANE][QW];

	// the high part always starts below a nonzero divisor
	always_comb begin
		for (int k = 0; k < QW; k++) begin
			for (int l = 0; l < NLANE; l++) begin
				tmp[l][k] = {rem_s[l][k], lo_s[l][k][QW-1]};
				fit[l][k] = tmp[l][k] >= {1'b0, d_s[l][k]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[QW-1:0], num_valid};
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < NLANE; l++) begin
			rem_s[l][0] <= num_hi[l];
			lo_s[l][0]  <= num_lo[l];
			q_s[l][0]   <= '0;
			d_s[l][0]   <= divisor[l];
		end
		side_s[0] <= side;
		for (int k = 0; k < QW; k++) begin
			for (int l = 0; l < NLANE; l++) begin
				rem_s[l][k+1] <= fit[l][k] ? DW'(tmp[l][k] - {1'b0, d_s[l][k]}) : tmp[l][k][DW-1:0];
				lo_s[l][k+1]  <= {lo_s[l][k][QW-2:0], 1'b0};
				q_s[l][k+1]   <= {q_s[l][k][QW-2:0], fit[l][k]};
				d_s[l][k+1]   <= d_s[l][k];
			end
			side_s[k+1] <= side_s[k];
		end
	end

	assign quo_valid = vld_s[QW];
	assign side_out  = side_s[QW];
	always_comb begin
		for (int l = 0; l < NLANE; l++)
			quo[l] = q_s[l][QW];
	end

endmodule

// ===== hdl/wdj_cos.sv =====
// unit vectors, bond angle cosine and the cosine row numerators
module wdj_cos import wdj_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     quo_valid,
	input  logic [NLANE-1:0][QW-1:0] quo,
	input  side_t                    side,
	output logic                     num_valid,
	output logic [NLANE-1:0][DW-1:0] num_hi,
	output logic [NLANE-1:0][QW-1:0] num_lo,
	output logic [NLANE-1:0][DW-1:0] divisor,
	output side_t                    side_out
);

	localparam logic [EW-1:0]             ONE_E  = EW'(1) << Q30;
	localparam logic signed [2*EW+1:0]    ONE_W  = (2*EW+2)'(1) << Q30;
	localparam logic signed [2*EW+1:0]    HALF_W = (2*EW+2)'(1) << (Q30 - 1);
	localparam logic signed [2*EW-1:0]    HALF_P = (2*EW)'(1) << (Q30 - 1);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	side_t nxt1, nxt5;
	logic signed [2*EW-1:0] p_s2 [3];
	logic signed [EW-1:0]   c_s3;
	logic signed [2*EW-1:0] ce1_s4 [3];
	logic signed [2*EW-1:0] ce2_s4 [3];
	logic [TW-1:0]          t_s5 [NLANE];
	logic [TW-1:0]          t_nxt [NLANE];

	logic [EW:0]            rnd  [NLANE];
	logic [EW-1:0]          emag [NLANE];
	logic [EW-1:0]          esgn [NLANE];
	logic signed [2*EW+1:0] dot, csh;
	logic signed [EW-1:0]   c_nxt;
	logic signed [2*EW-1:0] ew, rq;
	logic [TW-1:0]          tm [NLANE];
	logic [NW-1:0]          numw [NLANE];

	// stage 1: round the quotients into q2.30 unit components
	always_comb begin
		nxt1 = '0;
		for (int j = 0; j < NLANE; j++) begin
			rnd[j]  = {1'b0, quo[j][QW-1:2]} + (EW+1)'(1);
			emag[j] = rnd[j][EW:1];
			if (emag[j] > ONE_E)
				emag[j] = ONE_E;
			esgn[j] = side.neg[j] ? -emag[j] : emag[j];
		end
		for (int i = 0; i < 3; i++) begin
			nxt1.e1[i] = esgn[i];
			nxt1.e2[i] = esgn[3+i];
		end
		nxt1.len1 = side.len1;
		nxt1.len2 = side.len2;
		nxt1.gt   = side.len1 > side.len2;
		nxt1.lt   = side.len1 < side.len2;
		nxt1.deg  = side.len1 == '0 || side.len2 == '0;
		nxt1.fin  = side.fin;
	end

	// stage 3: cosine, rounded and clamped
	always_comb begin
		dot = (2*EW+2)'(p_s2[0]) + (2*EW+2)'(p_s2[1]) + (2*EW+2)'(p_s2[2]);
		csh = (dot + HALF_W) >>> Q30;
		if (csh > ONE_W)
			c_nxt = EW'(ONE_W);
		else if (csh < -ONE_W)
			c_nxt = EW'(-ONE_W);
		else
			c_nxt = csh[EW-1:0];
	end

	// stage 5: t = e_other - c * e_own
	always_comb begin
		nxt5 = side_s4;
		for (int j = 0; j < NLANE; j++) begin
			if (j < 3) begin
				ew = $signed(side_s4.e2[j]);
				rq = (ce1_s4[j] + HALF_P) >>> Q30;
			end else begin
				ew = $signed(side_s4.e1[j-3]);
				rq = (ce2_s4[j-3] + HALF_P) >>> Q30;
			end
			t_nxt[j]    = TW'(ew - rq);
			nxt5.neg[j] = t_nxt[j][TW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= quo_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= nxt1;
		side_s2 <= side_s1;
		for (int i = 0; i < 3; i++)
			p_s2[i] <= $signed(side_s1.e1[i]) * $signed(side_s1.e2[i]);
		side_s3 <= side_s2;
		c_s3    <= c_nxt;
		side_s4 <= side_s3;
		for (int i = 0; i < 3; i++) begin
			ce1_s4[i] <= c_s3 * $signed(side_s3.e1[i]);
			ce2_s4[i] <= c_s3 * $signed(side_s3.e2[i]);
		end
		side_s5 <= nxt5;
		for (int j = 0; j < NLANE; j++)
			t_s5[j] <= t_nxt[j];
	end

	// numerator |t| * 2^18 plus half the divisor, split for the divider
	always_comb begin
		for (int j = 0; j < NLANE; j++) begin
			tm[j]      = side_s5.neg[j] ? -t_s5[j] : t_s5[j];
			divisor[j] = (j < 3) ? DW'(side_s5.len1) : DW'(side_s5.len2);
			numw[j]    = NW'({tm[j], {COS_SHIFT{1'b0}}}) + NW'(divisor[j] >> 1);
			num_hi[j]  = numw[j][NW-1:QW];
			num_lo[j]  = numw[j][QW-1:0];
		end
	end

	assign num_valid = vld_s5;
	assign side_out  = side_s5;

endmodule

// ===== hdl/wdj_out.sv =====
// forms the three rows of nine values and sends them out one row a cycle
module wdj_out import wdj_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     quo_valid,
	input  logic [NLANE-1:0][QW-1:0] quo,
	input  side_t                    side,
	output logic                     row_valid,
	output row_t                     row,
	output logic                     last_row,
	output logic                     batch_end,
	output logic                     degenerate
);

	logic                 vld_s1, fin_s1, deg_s1;
	row_t                 rows_s1 [ROWS];
	row_t                 nxt [ROWS];
	logic [1:0]           cnt_q;
	logic                 valid_q, last_q, end_q, deg_q;
	row_t                 row_q;
	logic [1:0]           idx;
	logic                 emit;

	logic signed [XW-1:0] e1w, e2w, aw, bw, d12, r1o, r1h1, r1h2;

	always_comb begin
		for (int r = 0; r < ROWS; r++)
			nxt[r] = '0;
		for (int i = 0; i < 3; i++) begin
			e1w = $signed(side.e1[i]);
			e2w = $signed(side.e2[i]);
			aw  = {{(XW-QW){1'b0}}, quo[i]};
			bw  = {{(XW-QW){1'b0}}, quo[3+i]};
			if (side.neg[i])
				aw = -aw;
			if (side.neg[3+i])
				bw = -bw;
			d12  = e1w - e2w;
			r1o  = side.gt ? -d12 : side.lt ? d12 : '0;
			r1h1 = side.gt ? e1w : side.lt ? -e1w : '0;
			r1h2 = side.gt ? -e2w : side.lt ? e2w : '0;
			if (!side.deg) begin
				nxt[ROW_MEAN][i]   = sat(rsh(-(e1w + e2w), 15));
				nxt[ROW_MEAN][3+i] = sat(rsh(e1w, 15));
				nxt[ROW_MEAN][6+i] = sat(rsh(e2w, 15));
				nxt[ROW_DIFF][i]   = sat(rsh(r1o, 14));
				nxt[ROW_DIFF][3+i] = sat(rsh(r1h1, 14));
				nxt[ROW_DIFF][6+i] = sat(rsh(r1h2, 14));
				nxt[ROW_COS][i]    = sat(-(aw + bw));
				nxt[ROW_COS][3+i]  = sat(aw);
				nxt[ROW_COS][6+i]  = sat(bw);
			end
		end
	end

	// a new molecule arrives only after the previous three rows are out
	assign emit = vld_s1 | (cnt_q != 2'd0);
	assign idx  = vld_s1 ? 2'(ROW_MEAN) : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			vld_s1  <= quo_valid;
			valid_q <= emit;
			if (emit)
				cnt_q <= (idx == 2'(ROW_COS)) ? 2'(ROW_MEAN) : idx + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (quo_valid) begin
			for (int r = 0; r < ROWS; r++)
				rows_s1[r] <= nxt[r];
			fin_s1 <= side.fin;
			deg_s1 <= side.deg;
		end
		if (emit) begin
			row_q  <= rows_s1[idx];
			last_q <= idx == 2'(ROW_COS);
			end_q  <= (idx == 2'(ROW_COS)) & fin_s1;
			deg_q  <= deg_s1;
		end
	end

	assign row_valid  = valid_q;
	assign row        = row_q;
	assign last_row   = last_q;
	assign batch_end  = end_q;
	assign degenerate = deg_q;

endmodule

// ===== hdl/water_descriptor_jacobian.sv =====
// water descriptor jacobian top level
// path: the first row passes the input, square and sum registers, the root, the
// unit divider, the cosine stages, the cosine divider and the row registers; the
// other two rows follow back to back; as the three rows share one result port, a
// start is taken only while busy is low; a take holds busy until its count ends
// reset: arst_n clears all valid bits and the busy count, no rows after reset
module water_descriptor_jacobian import wdj_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [CW-1:0] o_x,
	input  logic signed [CW-1:0] o_y,
	input  logic signed [CW-1:0] o_z,
	input  logic signed [CW-1:0] h1_x,
	input  logic signed [CW-1:0] h1_y,
	input  logic signed [CW-1:0] h1_z,
	input  logic signed [CW-1:0] h2_x,
	input  logic signed [CW-1:0] h2_y,
	input  logic signed [CW-1:0] h2_z,
	input  logic                 final_molecule,
	output logic                 row_valid,
	output logic signed [CW-1:0] d_o_x,
	output logic signed [CW-1:0] d_o_y,
	output logic signed [CW-1:0] d_o_z,
	output logic signed [CW-1:0] d_h1_x,
	output logic signed [CW-1:0] d_h1_y,
	output logic signed [CW-1:0] d_h1_z,
	output logic signed [CW-1:0] d_h2_x,
	output logic signed [CW-1:0] d_h2_y,
	output logic signed [CW-1:0] d_h2_z,
	output logic                 last_row,
	output logic                 batch_end,
	output logic                 degenerate
);

	logic                      take;
	logic [$clog2(CPI)-1:0]    busy_q;
	logic                      vld_s1, vld_s2, vld_s3;
	vec3_t                     v1_s1, v2_s1, v1_s2, v2_s2, v1_s3, v2_s3;
	logic                      fin_s1, fin_s2, fin_s3;
	logic [2:0][SQW-1:0]       sq1_s2, sq2_s2;
	logic [SW-1:0]             sum1_s3, sum2_s3;
	logic [2:0][CW-1:0]        oc, h1c, h2c;
	logic [2:0][CW-1:0]        m1, m2;

	logic                      len_valid;
	logic [1:0][LW-1:0]        len;
	bond_t                     bond_in, bond_out;

	logic [NLANE-1:0][DW-1:0]  u_hi, u_d, c_hi, c_d;
	logic [NLANE-1:0][QW-1:0]  u_lo, c_lo, u_q, c_q;
	logic [CW-1:0]             um [NLANE];
	logic [NW-1:0]             unum [NLANE];
	side_t                     u_side, u_side_out, c_side, c_side_out;
	logic                      u_valid, c_valid, c_done;
	row_t                      row;

	assign take = start & ~busy;
	assign busy = busy_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= '0;
		else if (take)
			busy_q <= ($clog2(CPI))'(CPI - 1);
		else if (busy_q != '0)
			busy_q <= busy_q - 1'b1;
	end

	assign oc  = {o_z, o_y, o_x};
	assign h1c = {h1_z, h1_y, h1_x};
	assign h2c = {h2_z, h2_y, h2_x};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m1[i] = mag33(v1_s1[i]);
			m2[i] = mag33(v2_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			v1_s1[i] <= {h1c[i][CW-1], h1c[i]} - {oc[i][CW-1], oc[i]};
			v2_s1[i] <= {h2c[i][CW-1], h2c[i]} - {oc[i][CW-1], oc[i]};
			sq1_s2[i] <= m1[i] * m1[i];
			sq2_s2[i] <= m2[i] * m2[i];
		end
		fin_s1  <= final_molecule;
		v1_s2   <= v1_s1;
		v2_s2   <= v2_s1;
		fin_s2  <= fin_s1;
		sum1_s3 <= SW'(sq1_s2[0]) + SW'(sq1_s2[1]) + SW'(sq1_s2[2]);
		sum2_s3 <= SW'(sq2_s2[0]) + SW'(sq2_s2[1]) + SW'(sq2_s2[2]);
		v1_s3   <= v1_s2;
		v2_s3   <= v2_s2;
		fin_s3  <= fin_s2;
	end

	assign bond_in = '{v1: v1_s3, v2: v2_s3, fin: fin_s3};

	wdj_root u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_valid (vld_s3),
		.sum       ({sum2_s3, sum1_s3}),
		.bond      (bond_in),
		.len_valid (len_valid),
		.len       (len),
		.bond_out  (bond_out)
	);

	// unit component: |v| * 2^49 / length, two low quotient bits dropped later
	always_comb begin
		u_side      = '0;
		u_side.len1 = len[0];
		u_side.len2 = len[1];
		u_side.fin  = bond_out.fin;
		for (int j = 0; j < NLANE; j++) begin
			if (j < 3) begin
				um[j]         = mag33(bond_out.v1[j]);
				u_side.neg[j] = bond_out.v1[j][VW-1];
				u_d[j]        = DW'(len[0]);
			end else begin
				um[j]         = mag33(bond_out.v2[j-3]);
				u_side.neg[j] = bond_out.v2[j-3][VW-1];
				u_d[j]        = DW'(len[1]);
			end
			unum[j] = NW'({um[j], {UNIT_SHIFT{1'b0}}});
			u_hi[j] = unum[j][NW-1:QW];
			u_lo[j] = unum[j][QW-1:0];
		end
	end

	wdj_div u_unit_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (len_valid),
		.num_hi    (u_hi),
		.num_lo    (u_lo),
		.divisor   (u_d),
		.side      (u_side),
		.quo_valid (u_valid),
		.quo       (u_q),
		.side_out  (u_side_out)
	);

	wdj_cos u_cos (
		.clk       (clk),
		.arst_n    (arst_n),
		.quo_valid (u_valid),
		.quo       (u_q),
		.side      (u_side_out),
		.num_valid (c_valid),
		.num_hi    (c_hi),
		.num_lo    (c_lo),
		.divisor   (c_d),
		.side_out  (c_side)
	);

	wdj_div u_cos_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (c_valid),
		.num_hi    (c_hi),
		.num_lo    (c_lo),
		.divisor   (c_d),
		.side      (c_side),
		.quo_valid (c_done),
		.quo       (c_q),
		.side_out  (c_side_out)
	);

	wdj_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.quo_valid  (c_done),
		.quo        (c_q),
		.side       (c_side_out),
		.row_valid  (row_valid),
		.row        (row),
		.last_row   (last_row),
		.batch_end  (batch_end),
		.degenerate (degenerate)
	);

	assign d_o_x  = row[0];
	assign d_o_y  = row[1];
	assign d_o_z  = row[2];
	assign d_h1_x = row[3];
	assign d_h1_y = row[4];
	assign d_h1_z = row[5];
	assign d_h2_x = row[6];
	assign d_h2_y = row[7];
	assign d_h2_z = row[8];

endmodule

// ===== hdl/wdj_chk.sv =====
// port level checks for the water descriptor jacobian, bound to the top level
module wdj_chk import wdj_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 row_valid,
	input logic                 last_row,
	input logic                 batch_end,
	input logic                 degenerate,
	input logic signed [CW-1:0] d_o_x,
	input logic signed [CW-1:0] d_h1_y,
	input logic signed [CW-1:0] d_h2_z
);

	// a taken word blocks the next one for the following cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a word was taken");

	// the last row closes a run of three
	a_three_rows: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && last_row |-> $past(row_valid) && $past(row_valid, 2) && !$past(last_row))
		else $error("last row not preceded by two rows");

	a_rows_continue: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !last_row |=> row_valid)
		else $error("row run broken before the last row");

	a_batch_end: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && batch_end |-> last_row)
		else $error("batch end on a row that is not the last");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && degenerate |-> d_o_x == 0 && d_h1_y == 0 && d_h2_z == 0)
		else $error("degenerate row carries nonzero values");

endmodule

bind water_descriptor_jacobian wdj_chk u_wdj_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.row_valid  (row_valid),
	.last_row   (last_row),
	.batch_end  (batch_end),
	.degenerate (degenerate),
	.d_o_x      (d_o_x),
	.d_h1_y     (d_h1_y),
	.d_h2_z     (d_h2_z)
);
